// ----- src/sparse_matrix_sorted_store_macros.svh -----
// ----------------------------------------------------------------------------
// Sparse matrix sorted store - assertion macros
// Shared property forms for the port checker of the store.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_SORTED_STORE_MACROS_SVH
`define SPARSE_MATRIX_SORTED_STORE_MACROS_SVH

// Condition on the same edge implies a consequence on that edge.
`define SMSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smss assertion failed");

// Condition on one edge implies a consequence on the next edge.
`define SMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smss assertion failed");

// Condition on one edge implies a consequence on a later edge.
`define SMSS_ASSERT_TWO(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error("smss assertion failed");

`endif

// ----- src/smss_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix sorted store - package
// Sizes, operation and status codes, and controller types of the store.
// ----------------------------------------------------------------------------
package smss_pkg;

	// Storage sizes.
	localparam int CAPACITY    = 64;
	localparam int INDEX_BITS  = 8;
	localparam int VALUE_BITS  = 32;
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
	localparam int EXTENT_BITS = INDEX_BITS + 1;
	localparam int KEY_BITS    = 2 * INDEX_BITS;

	// Operation codes carried by the mode field.
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_INSERTED    = 3'd0,
		ST_OVERWRITTEN = 3'd1,
		ST_FULL        = 3'd2,
		ST_FOUND       = 3'd3,
		ST_NOT_FOUND   = 3'd4,
		ST_CLEARED     = 3'd5
	} status_t;

	// Controller states.
	typedef enum logic {
		S_IDLE  = 1'b0,
		S_APPLY = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic apply;
	} cmd_t;

endpackage

// ----- src/smss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix sorted store - controller
// Two-state sequencer: accept and compare, then apply and report one beat.
// ----------------------------------------------------------------------------
module smss_ctrl import smss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.apply   = 1'b0;
		busy        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_APPLY;
				end
			end
			S_APPLY: begin
				busy      = 1'b1;
				cmd.apply = 1'b1;
				state_d   = S_IDLE;
			end
		endcase
	end

	// The result beat follows the apply cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.apply;
		end
	end

	assign done = done_q;

endmodule

// ----- src/smss_datapath.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix sorted store - datapath
// A row of sorted entry cells with parallel key compare, shift insert,
// overwrite, matched-value select and the count and extent registers.
// ----------------------------------------------------------------------------
module smss_datapath import smss_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  logic [1:0]                    mode,
	input  logic [INDEX_BITS-1:0]         row_index,
	input  logic [INDEX_BITS-1:0]         col_index,
	input  logic signed [VALUE_BITS-1:0]  entry_value,
	output logic [2:0]                    status,
	output logic signed [VALUE_BITS-1:0]  read_value,
	output logic [COUNT_BITS-1:0]         stored_count,
	output logic [EXTENT_BITS-1:0]        row_extent,
	output logic [EXTENT_BITS-1:0]        col_extent
);

	// Entry cells, kept sorted by row then column below the count.
	logic [INDEX_BITS-1:0]        rows_q [CAPACITY];
	logic [INDEX_BITS-1:0]        cols_q [CAPACITY];
	logic signed [VALUE_BITS-1:0] vals_q [CAPACITY];

	logic [COUNT_BITS-1:0]  count_q;
	logic [EXTENT_BITS-1:0] rows_used_q;
	logic [EXTENT_BITS-1:0] cols_used_q;

	// Operation captured at accept.
	mode_t                        mode_q;
	logic [INDEX_BITS-1:0]        row_q;
	logic [INDEX_BITS-1:0]        col_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic [CAPACITY-1:0]          lt_q;
	logic [CAPACITY-1:0]          eq_q;

	logic [CAPACITY-1:0]          lt_d;
	logic [CAPACITY-1:0]          eq_d;
	logic [KEY_BITS-1:0]          in_key;

	logic                         found;
	logic                         full;
	logic                         is_insert;
	logic                         do_shift;
	logic                         do_write;
	logic                         grow;
	logic signed [VALUE_BITS-1:0] match_value;
	logic [EXTENT_BITS-1:0]       row_next;
	logic [EXTENT_BITS-1:0]       col_next;

	status_t                      res_status;
	logic signed [VALUE_BITS-1:0] res_value;
	status_t                      status_q;
	logic signed [VALUE_BITS-1:0] read_value_q;

	// Compare the incoming key against every occupied cell at once.
	assign in_key = {row_index, col_index};

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_d[i] = (COUNT_BITS'(i) < count_q) && ({rows_q[i], cols_q[i]} < in_key);
			eq_d[i] = (COUNT_BITS'(i) < count_q) && ({rows_q[i], cols_q[i]} == in_key);
		end
	end

	// Operation and compare flags are taken on the accept beat.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(mode);
			row_q  <= row_index;
			col_q  <= col_index;
			val_q  <= entry_value;
			lt_q   <= lt_d;
			eq_q   <= eq_d;
		end
	end

	// Decode the apply step.
	assign found     = |eq_q;
	assign full      = (count_q == COUNT_BITS'(CAPACITY));
	assign is_insert = (mode_q == MODE_INSERT);
	assign do_shift  = cmd.apply && is_insert && !found && !full;
	assign do_write  = cmd.apply && is_insert && found;
	assign grow      = is_insert && (found || !full);
	assign row_next  = {1'b0, row_q} + EXTENT_BITS'(1);
	assign col_next  = {1'b0, col_q} + EXTENT_BITS'(1);

	// Select the matched value; at most one cell matches.
	always_comb begin
		match_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match_value = match_value | (eq_q[i] ? vals_q[i] : '0);
		end
	end

	// Cell update: cells below the insert point hold, the insert point takes the
	// new entry, and cells above it take their lower neighbor.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_shift) begin
				if (!lt_q[i]) begin
					if (i == 0 || lt_q[(i == 0) ? 0 : i - 1]) begin
						rows_q[i] <= row_q;
						cols_q[i] <= col_q;
						vals_q[i] <= val_q;
					end else begin
						rows_q[i] <= rows_q[(i == 0) ? 0 : i - 1];
						cols_q[i] <= cols_q[(i == 0) ? 0 : i - 1];
						vals_q[i] <= vals_q[(i == 0) ? 0 : i - 1];
					end
				end
			end else if (do_write && eq_q[i]) begin
				vals_q[i] <= val_q;
			end
		end
	end

	// Count and extents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rows_used_q <= '0;
			cols_used_q <= '0;
		end else if (cmd.apply) begin
			if (mode_q == MODE_CLEAR) begin
				count_q     <= '0;
				rows_used_q <= '0;
				cols_used_q <= '0;
			end else begin
				if (do_shift) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
				if (grow && (row_next > rows_used_q)) begin
					rows_used_q <= row_next;
				end
				if (grow && (col_next > cols_used_q)) begin
					cols_used_q <= col_next;
				end
			end
		end
	end

	// Result status and value.
	always_comb begin
		res_status = ST_NOT_FOUND;
		res_value  = '0;
		unique case (mode_q)
			MODE_INSERT: begin
				if (found) begin
					res_status = ST_OVERWRITTEN;
				end else if (full) begin
					res_status = ST_FULL;
				end else begin
					res_status = ST_INSERTED;
				end
			end
			MODE_LOOKUP: begin
				if (found) begin
					res_status = ST_FOUND;
					res_value  = match_value;
				end
			end
			MODE_CLEAR: begin
				res_status = ST_CLEARED;
			end
			MODE_NONE: begin
				res_status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status_q     <= res_status;
			read_value_q <= res_value;
		end
	end

	assign status       = status_q;
	assign read_value   = read_value_q;
	assign stored_count = count_q;
	assign row_extent   = rows_used_q;
	assign col_extent   = cols_used_q;

endmodule

// ----- src/sparse_matrix_sorted_store.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix sorted store - top level
// Sorted (row, column, value) store with insert, lookup and clear.
// ----------------------------------------------------------------------------
// The cycle in which start is taken compares the key against all 64 entry
// cells in parallel; the next cycle, while busy is high, shifts or overwrites
// the cells and registers the result. The result beat shows on done in the
// following cycle, when busy is already low again, so a new start may be
// given in the same cycle as done. The result is shown for one cycle only and
// cannot be held off; stored_count and the extents keep their values until
// the next operation. No clearing pass runs after reset.
module sparse_matrix_sorted_store import smss_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [INDEX_BITS-1:0]         row_index,
	input  logic [INDEX_BITS-1:0]         col_index,
	input  logic signed [VALUE_BITS-1:0]  entry_value,
	output logic                          done,
	output logic [2:0]                    status,
	output logic signed [VALUE_BITS-1:0]  read_value,
	output logic [COUNT_BITS-1:0]         stored_count,
	output logic [EXTENT_BITS-1:0]        row_extent,
	output logic [EXTENT_BITS-1:0]        col_extent
);

	cmd_t cmd;

	// Sequencer.
	smss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Entry cells and result registers.
	smss_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode),
		.row_index    (row_index),
		.col_index    (col_index),
		.entry_value  (entry_value),
		.status       (status),
		.read_value   (read_value),
		.stored_count (stored_count),
		.row_extent   (row_extent),
		.col_extent   (col_extent)
	);

endmodule

// ----- src/smss_checker.sv -----
// ----------------------------------------------------------------------------
// Sparse matrix sorted store - port checker
// Timing and result checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparse_matrix_sorted_store_macros.svh"

module smss_checker import smss_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [2:0]                    status,
	input logic signed [VALUE_BITS-1:0]  read_value,
	input logic [COUNT_BITS-1:0]         stored_count,
	input logic [EXTENT_BITS-1:0]        row_extent,
	input logic [EXTENT_BITS-1:0]        col_extent
);

	// An accepted operation raises busy in the next cycle, holding off a new start.
	`SMSS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// Every accepted operation yields its result beat on done, through the apply state and the done register.
	`SMSS_ASSERT_TWO(a_accept_done, clk, arst_n, start && !busy, done)

	// A clear leaves an empty store with zero extents.
	`SMSS_ASSERT_NOW(a_clear_empty, clk, arst_n, done && (status == ST_CLEARED),
		(stored_count == '0) && (row_extent == '0) && (col_extent == '0))

	// Only a successful lookup returns a nonzero value.
	`SMSS_ASSERT_NOW(a_value_zero, clk, arst_n, done && (status != ST_FOUND),
		read_value == '0)

endmodule

bind sparse_matrix_sorted_store smss_checker u_smss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.read_value   (read_value),
	.stored_count (stored_count),
	.row_extent   (row_extent),
	.col_extent   (col_extent)
);
